// File: hw/rtl/iss_pkg.sv
// ---------------------------------------------------------------------------
// iss_pkg: shared types and constants for the indexed sequence store
// Field widths, opcode and status codes, and the control/status bundles
// passed between the controller and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package iss_pkg;

  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int POS_W        = 9;
  localparam int ST_W         = 2;
  localparam int LEN_W        = 9;
  localparam int DEF_CAPACITY = 256;

  // Opcodes
  localparam logic [OP_W-1:0] OP_READ     = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

  // Result status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // What a request does to the store once decoded
  typedef enum logic [1:0] {
    K_NONE,
    K_READ,
    K_INS,
    K_DEL
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture request, issue lookup read
    logic cap_rd;  // capture lookup read data as result value
    logic step;    // issue one shift read and advance the scan index
    logic commit;  // place inserted value, update count
    logic emit;    // load output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic look_now;   // incoming request is an in-range read
    logic shift_now;  // incoming request needs a shift pass
    logic last;       // current scan index is the final one
    logic slot_free;  // output register can take a result
  } sts_t;

endpackage

// File: hw/rtl/iss_ram.sv
// ---------------------------------------------------------------------------
// iss_ram: generic simple dual-port RAM
// One write port, one read port, registered read data, no reset on contents.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module iss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/iss_ctrl.sv
// ---------------------------------------------------------------------------
// iss_ctrl: request sequencer for the indexed sequence store
// Steps each request through lookup, shift, commit and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module iss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  iss_pkg::sts_t sts,
  output iss_pkg::cmd_t cmd
);

  import iss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SHIFT,
    S_DRAIN,
    S_COMMIT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.look_now) begin
            state_nxt = S_LOOK;
          end else if (sts.shift_now) begin
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_LOOK: begin
        cmd.cap_rd = 1'b1;
        state_nxt  = S_COMMIT;
      end
      S_SHIFT: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_nxt = S_DRAIN;
        end
      end
      // let the final moved word land
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// File: hw/rtl/iss_dp.sv
// ---------------------------------------------------------------------------
// iss_dp: datapath for the indexed sequence store
// Request decode, element RAM, shift scan, element count and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module iss_dp #(
  parameter int CAPACITY = iss_pkg::DEF_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  iss_pkg::cmd_t                      cmd,
  output iss_pkg::sts_t                      sts,
  input  logic [iss_pkg::OP_W-1:0]           in_opcode,
  input  logic [iss_pkg::POS_W-1:0]          in_position,
  input  logic signed [iss_pkg::DATA_W-1:0]  in_item_value,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic signed [iss_pkg::DATA_W-1:0]  out_read_value,
  output logic [iss_pkg::ST_W-1:0]           out_status,
  output logic [iss_pkg::LEN_W-1:0]          out_length
);

  import iss_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request decode
  logic [CW-1:0]     pos_w, cnt_w, cnt_m1, pos_p1;
  logic              full;
  kind_t             dec_kind;
  logic [ST_W-1:0]   dec_st;
  logic [DATA_W-1:0] dec_val;
  logic [AW-1:0]     dec_end, dec_start;
  logic              dec_shift;

  // Registers
  logic [CNT_W-1:0]         count_r, count_nxt;
  kind_t                    kind_r, kind_nxt;
  logic [ST_W-1:0]          st_r, st_nxt;
  logic [DATA_W-1:0]        res_val_r, res_val_nxt;
  logic [DATA_W-1:0]        val_r, val_nxt;
  logic [AW-1:0]            end_r, end_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic                     pend_r, pend_nxt;
  logic [AW-1:0]            pend_addr_r, pend_addr_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]        out_val_r, out_val_nxt;
  logic [ST_W-1:0]          out_st_r, out_st_nxt;
  logic [LEN_W-1:0]         out_len_r, out_len_nxt;

  // RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  logic [CW-1:0]     len_w;

  assign pos_w  = CW'(in_position);
  assign cnt_w  = CW'(count_r);
  assign cnt_m1 = cnt_w - CW'(1);
  assign pos_p1 = pos_w + CW'(1);
  assign full   = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    dec_kind  = K_NONE;
    dec_st    = ST_DONE;
    dec_val   = '0;
    dec_end   = '0;
    dec_start = cnt_m1[AW-1:0];
    dec_shift = 1'b0;
    unique case (in_opcode)
      OP_READ: begin
        if (pos_w < cnt_w) begin
          dec_kind = K_READ;
        end else begin
          dec_st  = ST_RANGE;
          dec_val = '1;
        end
      end
      OP_INS_HEAD: begin
        if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_kind  = K_INS;
          dec_end   = '0;
          dec_shift = (count_r != '0);
        end
      end
      OP_INS_TAIL: begin
        if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_kind = K_INS;
          dec_end  = cnt_w[AW-1:0];
        end
      end
      OP_INS_AT: begin
        if (pos_w > cnt_w) begin
          dec_st = ST_RANGE;
        end else if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_kind  = K_INS;
          dec_end   = pos_w[AW-1:0];
          dec_shift = (pos_w != cnt_w);
        end
      end
      OP_DELETE: begin
        if (pos_w >= cnt_w) begin
          dec_st = ST_RANGE;
        end else begin
          dec_kind  = K_DEL;
          dec_end   = cnt_m1[AW-1:0];
          dec_start = pos_p1[AW-1:0];
          dec_shift = (pos_p1 != cnt_w);
        end
      end
      default: begin
      end
    endcase
  end

  // Next-state logic
  always_comb begin
    kind_nxt      = kind_r;
    st_nxt        = st_r;
    res_val_nxt   = res_val_r;
    val_nxt       = val_r;
    end_nxt       = end_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    pend_nxt      = cmd.step;
    pend_addr_nxt = pend_addr_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    out_len_nxt   = out_len_r;
    out_valid_nxt = out_valid_r & out_stall;

    if (cmd.load) begin
      kind_nxt    = dec_kind;
      st_nxt      = dec_st;
      res_val_nxt = dec_val;
      val_nxt     = in_item_value;
      end_nxt     = dec_end;
      idx_nxt     = dec_start;
    end
    if (cmd.cap_rd) begin
      res_val_nxt = ram_rdata;
    end
    // inserts walk down and move each word up; deletes walk up and move down
    if (cmd.step) begin
      if (kind_r == K_INS) begin
        idx_nxt       = idx_r - AW'(1);
        pend_addr_nxt = idx_r + AW'(1);
      end else begin
        idx_nxt       = idx_r + AW'(1);
        pend_addr_nxt = idx_r - AW'(1);
      end
    end
    if (cmd.commit) begin
      if (kind_r == K_INS) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (kind_r == K_DEL) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = res_val_r;
      out_st_nxt    = st_r;
      out_len_nxt   = len_w[LEN_W-1:0];
    end
  end

  assign len_w = CW'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      kind_r      <= K_NONE;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r        <= st_nxt;
    res_val_r   <= res_val_nxt;
    val_r       <= val_nxt;
    end_r       <= end_nxt;
    idx_r       <= idx_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_val_r   <= out_val_nxt;
    out_st_r    <= out_st_nxt;
    out_len_r   <= out_len_nxt;
  end

  // Read port: lookup address on load, scan index otherwise.
  // Write port: pending shifted word, else the inserted value on commit.
  assign ram_raddr = cmd.load ? pos_w[AW-1:0] : idx_r;
  assign ram_we    = pend_r | (cmd.commit & (kind_r == K_INS));
  assign ram_waddr = pend_r ? pend_addr_r : end_r;
  assign ram_wdata = pend_r ? ram_rdata : val_r;

  iss_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign sts.look_now  = (dec_kind == K_READ);
  assign sts.shift_now = dec_shift;
  assign sts.last      = (idx_r == end_r);
  assign sts.slot_free = ~out_valid_r | ~out_stall;

  assign out_valid      = out_valid_r;
  assign out_read_value = out_val_r;
  assign out_status     = out_st_r;
  assign out_length     = out_len_r;

endmodule

// File: hw/rtl/indexed_sequence_store.sv
// ---------------------------------------------------------------------------
// indexed_sequence_store: ordered store of signed 32-bit values
// Holds up to CAPACITY values in sequence order; each request reads,
// inserts or deletes one element and returns exactly one result.
//
// Request channel (in_*): in_valid/in_stall handshake carrying opcode,
// position and item value. A request is taken when in_valid is high and
// in_stall is low. Only one request is in flight at a time; in_stall is
// high from the cycle after acceptance until the result is loaded into
// the output register.
// Result channel (out_*): out_valid/out_stall, carrying read value,
// status and the length after the request. The output register parts the
// two sides, so a new request is taken while an earlier result still waits.
// A read in range passes through lookup, commit and result hand-off; any
// other request that moves nothing (rejects, appends, deleting the last
// element, unused opcodes) goes straight to commit and hand-off; an insert
// or delete that moves elements first runs a shift pass and a drain step.
// The shift pass moves one element per cycle through the single read and
// single write port of the element RAM.
// Reset clears the length and all control state; RAM contents are not
// cleared (entries at or above the length are never read). If the
// receiver stalls, the finished result holds in the output register and
// the next request waits in its final step until the register frees up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_sequence_store #(
  parameter int CAPACITY = iss_pkg::DEF_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [iss_pkg::OP_W-1:0]           in_opcode,
  input  logic [iss_pkg::POS_W-1:0]          in_position,
  input  logic signed [iss_pkg::DATA_W-1:0]  in_item_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [iss_pkg::DATA_W-1:0]  out_read_value,
  output logic [iss_pkg::ST_W-1:0]           out_status,
  output logic [iss_pkg::LEN_W-1:0]          out_length
);

  import iss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: walks each request through its steps
  iss_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Datapath: decode, element RAM, shift scan, count, output register
  iss_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_opcode     (in_opcode),
    .in_position   (in_position),
    .in_item_value (in_item_value),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_read_value(out_read_value),
    .out_status    (out_status),
    .out_length    (out_length)
  );

  // Hold off further requests once one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one still in flight");

  // A new result only comes out of a request in progress
  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in progress");

  // Only a successful read returns data; a full-store reject returns zero
  a_full_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_read_value == '0)
    else $error("full-store reject carried a nonzero read value");

  // No two controller commands are ever issued together
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.cap_rd, cmd.step, cmd.commit, cmd.emit}))
    else $error("controller issued overlapping commands");

endmodule
